@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BWO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BWO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BWO_ASSERT(lbl, prop, msg)
`define BWO_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hdl/bwo_pkg.sv @@
// Shared types, constants, curve ROM and microprogram of the Bezier wave oscillator.
package bwo_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [16:0] ONE_T = 17'h10000;

  localparam int SEGMENTS_DEF     = 4;
  localparam int NEWTON_STEPS_DEF = 4;
  localparam int BISECT_STEPS_DEF = 4;

  localparam int ACC_W = 24;
  localparam int D1_W  = ACC_W + 2;
  localparam int DX_W  = ACC_W + 1;
  localparam int NUM_W = DX_W + FRAC_BITS;

  localparam logic [3:0] STEP_VAL_LAST = 4'd10;
  localparam logic [3:0] STEP_DRAIN    = 4'd14;

  // Control points, signed Q2.14: [segment][point]
  localparam logic signed [15:0] ROM_X [4][4] = '{
    '{16'sd0,     16'sd2490,  16'sd3162,  16'sd4424},
    '{16'sd4424,  16'sd5063,  16'sd6308,  16'sd9011},
    '{16'sd9011,  16'sd11731, 16'sd12534, 16'sd14041},
    '{16'sd14041, 16'sd15548, 16'sd14778, 16'sd16384}
  };
  localparam logic signed [15:0] ROM_Y [4][4] = '{
    '{16'sd15630,  16'sd15630,  -16'sd197,   -16'sd11649},
    '{-16'sd11649, -16'sd16384, -16'sd16335, -16'sd16286},
    '{-16'sd16286, -16'sd16237, -16'sd17416, -16'sd10551},
    '{-16'sd10551, -16'sd3703,  16'sd15630,  16'sd15630}
  };

  typedef enum logic [3:0] {
    A_U, A_UU, A_TT, A_UT, A_B0, A_B1, A_B2, A_B3, A_T
  } asel_e;

  typedef enum logic [3:0] {
    B_U, B_T, B_TT, B_P0, B_P1, B_P2, B_P3, B_D10, B_D21, B_D32
  } bsel_e;

  typedef enum logic [3:0] {
    D_NONE, D_UU, D_TT, D_UT, D_B0, D_B1, D_B2, D_B3,
    D_ACC_SET, D_ACC_ADD, D_DAC_SET, D_DAC_ADD2, D_DAC_ADD
  } dst_e;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_SETUP, ACT_NDEC, ACT_NUPD, ACT_BDEC, ACT_OUTPUT
  } act_e;

  typedef struct packed {
    asel_e a_sel;
    bsel_e b_sel;
    dst_e  dst;
  } mop_t;

  typedef struct packed {
    act_e act;
    mop_t mop;
    logic use_y;
    logic load_phase;
  } ctrl_t;

  typedef struct packed {
    logic dx_zero;
    logic d1_zero;
    logic div_busy;
  } stat_t;

  // Control point scaled to Q.16 (Q2.14 shifted left by two)
  function automatic logic signed [17:0] rom_pt(logic [1:0] seg, logic [1:0] k, logic use_y);
    logic signed [15:0] v;
    v = use_y ? ROM_Y[seg][k] : ROM_X[seg][k];
    return {v, 2'b00};
  endfunction

  // One multiply per step; each product is registered together with its destination, then written back.
  function automatic mop_t prog_cmd(logic [3:0] step);
    mop_t m;
    m = '{a_sel: A_U, b_sel: B_U, dst: D_NONE};
    case (step)
      4'd0:    m = '{a_sel: A_U,  b_sel: B_U,   dst: D_UU};
      4'd1:    m = '{a_sel: A_U,  b_sel: B_T,   dst: D_UT};
      4'd2:    m = '{a_sel: A_T,  b_sel: B_T,   dst: D_TT};
      4'd3:    m = '{a_sel: A_UU, b_sel: B_U,   dst: D_B0};
      4'd4:    m = '{a_sel: A_UU, b_sel: B_T,   dst: D_B1};
      4'd5:    m = '{a_sel: A_U,  b_sel: B_TT,  dst: D_B2};
      4'd6:    m = '{a_sel: A_TT, b_sel: B_T,   dst: D_B3};
      4'd7:    m = '{a_sel: A_B0, b_sel: B_P0,  dst: D_ACC_SET};
      4'd8:    m = '{a_sel: A_B1, b_sel: B_P1,  dst: D_ACC_ADD};
      4'd9:    m = '{a_sel: A_B2, b_sel: B_P2,  dst: D_ACC_ADD};
      4'd10:   m = '{a_sel: A_B3, b_sel: B_P3,  dst: D_ACC_ADD};
      4'd11:   m = '{a_sel: A_UU, b_sel: B_D10, dst: D_DAC_SET};
      4'd12:   m = '{a_sel: A_UT, b_sel: B_D21, dst: D_DAC_ADD2};
      4'd13:   m = '{a_sel: A_TT, b_sel: B_D32, dst: D_DAC_ADD};
      default: m = '{a_sel: A_U,  b_sel: B_U,   dst: D_NONE};
    endcase
    return m;
  endfunction

endpackage

@@ hdl/bwo_div.sv @@
// Serial restoring divider, signed operands, quotient truncated toward zero.
module bwo_div #(
  parameter int NW = 41,
  parameter int DW = 26
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [DW-1:0] den_i,
  output logic                 busy_o,
  output logic signed [NW:0]   quo_o
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] a_q, a_d;
  logic [DW-1:0] r_q, r_d, dm_q, dm_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          neg_q, neg_d, busy_q, busy_d;
  logic [DW+1:0] trial;

  always_comb begin
    trial  = {1'b0, r_q, a_q[NW-1]} - {2'b00, dm_q};
    a_d    = a_q;
    r_d    = r_q;
    dm_d   = dm_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      a_d    = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
      dm_d   = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
      neg_d  = num_i[NW-1] ^ den_i[DW-1];
      r_d    = '0;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DW+1]) begin
        r_d = trial[DW-1:0];
        a_d = {a_q[NW-2:0], 1'b1};
      end else begin
        r_d = {r_q[DW-2:0], a_q[NW-1]};
        a_d = {a_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    r_q   <= r_d;
    dm_q  <= dm_d;
    neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = neg_q ? -$signed({1'b0, a_q}) : $signed({1'b0, a_q});
endmodule

@@ hdl/bwo_datapath.sv @@
// Datapath: segment pick, shared multiplier, bracket registers, divider and output.
module bwo_datapath #(
  parameter int SEGMENTS = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bwo_pkg::ctrl_t ctrl_i,
  input  logic [15:0]    phase_i,
  output bwo_pkg::stat_t stat_o,
  output logic [15:0]    sample_o
);
  import bwo_pkg::*;

  logic [15:0] phase_q;
  logic [1:0]  seg_q, prior_seg_q, seg_find;
  logic [16:0] t_q, lo_q, hi_q, prior_t_q;
  logic [16:0] uu_q, tt_q, ut_q, b0_q, b3_q;
  logic [17:0] b1_q, b2_q;
  logic signed [ACC_W-1:0] acc_q, dac_q;
  logic signed [39:0] prod_q;
  dst_e        dst_q;
  logic [15:0] out_q;

  logic [16:0] u;
  logic signed [19:0] a_op, b_op;
  logic signed [ACC_W-1:0] sh, sh3;
  logic signed [17:0] p0, p1, p2, p3;
  logic signed [DX_W-1:0] dx;
  logic signed [D1_W-1:0] d1;
  logic [16:0] nlo, nhi, mid_n, mid_c;
  logic signed [NUM_W:0] quo;
  logic signed [NUM_W+1:0] tn;
  logic        div_busy, div_start, gt;
  logic signed [ACC_W-1:0] yc;
  logic signed [ACC_W-1:0] ny;

  assign u  = ONE_T - t_q;
  assign p0 = rom_pt(seg_q, 2'd0, ctrl_i.use_y);
  assign p1 = rom_pt(seg_q, 2'd1, ctrl_i.use_y);
  assign p2 = rom_pt(seg_q, 2'd2, ctrl_i.use_y);
  assign p3 = rom_pt(seg_q, 2'd3, ctrl_i.use_y);

  // First segment whose end x reaches the phase; the last segment otherwise
  always_comb begin
    seg_find = 2'(SEGMENTS - 1);
    for (int i = SEGMENTS - 1; i >= 0; i--) begin
      if ($signed({2'b00, phase_q}) <= $signed({ROM_X[i % 4][3], 2'b00})) begin
        seg_find = 2'(i);
      end
    end
  end

  always_comb begin
    case (ctrl_i.mop.a_sel)
      A_U:     a_op = $signed({3'b000, u});
      A_T:     a_op = $signed({3'b000, t_q});
      A_UU:    a_op = $signed({3'b000, uu_q});
      A_TT:    a_op = $signed({3'b000, tt_q});
      A_UT:    a_op = $signed({3'b000, ut_q});
      A_B0:    a_op = $signed({3'b000, b0_q});
      A_B1:    a_op = $signed({2'b00, b1_q});
      A_B2:    a_op = $signed({2'b00, b2_q});
      A_B3:    a_op = $signed({3'b000, b3_q});
      default: a_op = '0;
    endcase
    case (ctrl_i.mop.b_sel)
      B_U:     b_op = $signed({3'b000, u});
      B_T:     b_op = $signed({3'b000, t_q});
      B_TT:    b_op = $signed({3'b000, tt_q});
      B_P0:    b_op = 20'(p0);
      B_P1:    b_op = 20'(p1);
      B_P2:    b_op = 20'(p2);
      B_P3:    b_op = 20'(p3);
      B_D10:   b_op = 20'(p1) - 20'(p0);
      B_D21:   b_op = 20'(p2) - 20'(p1);
      B_D32:   b_op = 20'(p3) - 20'(p2);
      default: b_op = '0;
    endcase
  end

  // Floor shift of the registered product back to Q.16
  assign sh  = prod_q[39:16];
  assign sh3 = sh + (sh <<< 1);

  assign dx = $signed({acc_q[ACC_W-1], acc_q}) - $signed({{(DX_W-16){1'b0}}, phase_q});
  assign d1 = $signed({{2{dac_q[ACC_W-1]}}, dac_q}) + $signed({dac_q[ACC_W-1], dac_q, 1'b0});
  assign gt = $signed({acc_q[ACC_W-1], acc_q}) > $signed({{(DX_W-16){1'b0}}, phase_q});

  assign nlo   = (dx > 0) ? lo_q : t_q;
  assign nhi   = (dx > 0) ? t_q : hi_q;
  assign mid_n = 17'(({1'b0, nlo} + {1'b0, nhi}) >> 1);
  assign mid_c = 17'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

  assign div_start = (ctrl_i.act == ACT_NDEC) && (dx != 0) && (d1 != 0);

  bwo_div #(.NW(NUM_W), .DW(D1_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({dx, {FRAC_BITS{1'b0}}}),
    .den_i   (d1),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  assign tn = $signed({{(NUM_W - 16){1'b0}}, t_q}) - $signed({quo[NUM_W], quo});

  always_comb begin
    yc = acc_q;
    if (acc_q < -$signed({{(ACC_W-17){1'b0}}, ONE_T})) yc = -$signed({{(ACC_W-17){1'b0}}, ONE_T});
    if (acc_q >  $signed({{(ACC_W-17){1'b0}}, ONE_T})) yc =  $signed({{(ACC_W-17){1'b0}}, ONE_T});
    ny = -yc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_t_q   <= '0;
      prior_seg_q <= '0;
      dst_q       <= D_NONE;
    end else begin
      dst_q <= ctrl_i.mop.dst;
      if (ctrl_i.act == ACT_OUTPUT) begin
        prior_t_q   <= t_q;
        prior_seg_q <= seg_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_op * b_op;
    if (ctrl_i.load_phase) begin
      phase_q <= phase_i;
    end
    case (dst_q)
      D_UU:       uu_q  <= sh[16:0];
      D_TT:       tt_q  <= sh[16:0];
      D_UT:       ut_q  <= sh[16:0];
      D_B0:       b0_q  <= sh[16:0];
      D_B1:       b1_q  <= sh3[17:0];
      D_B2:       b2_q  <= sh3[17:0];
      D_B3:       b3_q  <= sh[16:0];
      D_ACC_SET:  acc_q <= sh;
      D_ACC_ADD:  acc_q <= acc_q + sh;
      D_DAC_SET:  dac_q <= sh;
      D_DAC_ADD2: dac_q <= dac_q + (sh <<< 1);
      D_DAC_ADD:  dac_q <= dac_q + sh;
      default:    ;
    endcase
    case (ctrl_i.act)
      ACT_SETUP: begin
        seg_q <= seg_find;
        t_q   <= (seg_find != prior_seg_q) ? '0 : prior_t_q;
        lo_q  <= '0;
        hi_q  <= ONE_T;
      end
      ACT_NDEC: begin
        if (dx != 0) begin
          lo_q <= nlo;
          hi_q <= nhi;
          if (d1 == 0) begin
            t_q <= mid_n;
          end
        end
      end
      ACT_NUPD: begin
        if (tn < $signed({{(NUM_W - 16){1'b0}}, lo_q}) ||
            tn > $signed({{(NUM_W - 16){1'b0}}, hi_q})) begin
          t_q <= mid_c;
        end else begin
          t_q <= tn[16:0];
        end
      end
      ACT_BDEC: begin
        if (gt) begin
          hi_q <= t_q;
          t_q  <= 17'(({1'b0, lo_q} + {1'b0, t_q}) >> 1);
        end else begin
          lo_q <= t_q;
          t_q  <= 17'(({1'b0, t_q} + {1'b0, hi_q}) >> 1);
        end
      end
      ACT_OUTPUT: begin
        // Q.16 to Q1.15 by floor shift; only +1.0 needs saturating
        if (ny > $signed(ACC_W'(65535))) begin
          out_q <= 16'h7FFF;
        end else begin
          out_q <= ny[16:1];
        end
      end
      default: ;
    endcase
  end

  assign stat_o.dx_zero  = (dx == 0);
  assign stat_o.d1_zero  = (d1 == 0);
  assign stat_o.div_busy = div_busy;
  assign sample_o        = out_q;
endmodule

@@ hdl/bwo_ctrl.sv @@
// Sequencer for the Newton, bisection and output phases.
module bwo_ctrl #(
  parameter int NEWTON_STEPS = 4,
  parameter int BISECT_STEPS = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  bwo_pkg::stat_t stat_i,
  output bwo_pkg::ctrl_t ctrl_o
);
  import bwo_pkg::*;

  localparam int NCW = $clog2(NEWTON_STEPS + 1);
  localparam int BCW = $clog2(BISECT_STEPS + 2);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_NEVAL, S_NDEC, S_NDIV, S_NUPD, S_BEVAL, S_BDEC, S_FEVAL, S_DONE
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] step_q, step_d;
  logic [NCW-1:0] ncnt_q, ncnt_d;
  logic [BCW-1:0] bcnt_q, bcnt_d;
  logic       out_valid_q, out_valid_d;
  state_e     after_newton;
  logic       n_last;

  assign after_newton = (BISECT_STEPS == 0) ? S_FEVAL : S_BEVAL;
  assign n_last       = (ncnt_q == NCW'(NEWTON_STEPS - 1));

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    ncnt_d      = ncnt_q;
    bcnt_d      = bcnt_q;
    ctrl_o      = '{act: ACT_NONE, mop: prog_cmd(STEP_DRAIN), use_y: 1'b0, load_phase: 1'b0};
    in_ready_o  = 1'b0;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o        = 1'b1;
        ctrl_o.load_phase = in_valid_i;
        if (in_valid_i) state_d = S_SETUP;
      end
      S_SETUP: begin
        ctrl_o.act = ACT_SETUP;
        step_d     = '0;
        ncnt_d     = '0;
        bcnt_d     = '0;
        state_d    = S_NEVAL;
      end
      S_NEVAL, S_BEVAL, S_FEVAL: begin
        ctrl_o.mop   = prog_cmd(step_q);
        ctrl_o.use_y = (state_q == S_FEVAL);
        if (step_q == STEP_DRAIN) begin
          step_d = '0;
          unique case (state_q)
            S_NEVAL: state_d = S_NDEC;
            S_BEVAL: state_d = S_BDEC;
            default: state_d = S_DONE;
          endcase
        end else if (step_q == STEP_VAL_LAST && state_q != S_NEVAL) begin
          step_d = STEP_DRAIN;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      S_NDEC: begin
        ctrl_o.act = ACT_NDEC;
        if (stat_i.dx_zero) begin
          state_d = after_newton;
        end else if (stat_i.d1_zero) begin
          ncnt_d  = ncnt_q + NCW'(1);
          state_d = n_last ? after_newton : S_NEVAL;
        end else begin
          state_d = S_NDIV;
        end
      end
      S_NDIV: begin
        if (!stat_i.div_busy) state_d = S_NUPD;
      end
      S_NUPD: begin
        ctrl_o.act = ACT_NUPD;
        ncnt_d     = ncnt_q + NCW'(1);
        state_d    = n_last ? after_newton : S_NEVAL;
      end
      S_BDEC: begin
        ctrl_o.act = ACT_BDEC;
        bcnt_d     = bcnt_q + BCW'(1);
        state_d    = (bcnt_q == BCW'(BISECT_STEPS - 1)) ? S_FEVAL : S_BEVAL;
      end
      S_DONE: begin
        // Hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.act  = ACT_OUTPUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      ncnt_q      <= '0;
      bcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      ncnt_q      <= ncnt_d;
      bcnt_q      <= bcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

@@ hdl/bezier_wave_oscillator_core.sv @@
// Top level of the Bezier wave oscillator: stream ports, sequencer and datapath.
//
//  channel   direction  tdata contents (lowest bit up)   accepted when
//  s_axis    in         phase[15:0], unsigned Q0.16      tvalid && tready
//  m_axis    out        wave_sample[15:0], signed Q1.15  tvalid && tready
//
// One phase transaction at a time. Once the result is written the sequencer returns to
// idle and only then takes the next phase. A Newton step runs the single shared
// multiplier, one product a cycle, and then the 41-iteration serial divider; a bisection
// step and the final evaluation skip the derivative products and the divider.
// A Newton step that converges or meets a zero derivative skips the divider.
// Reset clears the sequencer, the divider's busy flag and count, the pending product
// destination and the stored t and segment; nothing else is swept.
// A finished sample waits in the output register; a stalled output only holds
// the next result back once it is ready to be written.
module bezier_wave_oscillator_core #(
  parameter int SEGMENTS     = bwo_pkg::SEGMENTS_DEF,
  parameter int NEWTON_STEPS = bwo_pkg::NEWTON_STEPS_DEF,
  parameter int BISECT_STEPS = bwo_pkg::BISECT_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] phase
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [15:0] wave_sample
);
  import bwo_pkg::*;

  `include "assert_macros.svh"

  ctrl_t ctrl;
  stat_t stat;

  // Sequencer: walks setup, Newton, bisection and final evaluation
  bwo_ctrl #(
    .NEWTON_STEPS (NEWTON_STEPS),
    .BISECT_STEPS (BISECT_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // Datapath: curve arithmetic, bracket, divider and output register
  bwo_datapath #(
    .SEGMENTS (SEGMENTS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .phase_i  (s_axis_tdata_i),
    .stat_o   (stat),
    .sample_o (m_axis_tdata_o)
  );

  // Only one transaction in flight: ready drops straight after an accept
  `BWO_ASSERT(a_one_in_flight, (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o, "second phase accepted while busy")
  // A new result appears only through the output action
  `BWO_ASSERT(a_out_from_action, $rose(m_axis_tvalid_o) |-> $past(ctrl.act == ACT_OUTPUT), "output valid without a result")
  // The divider is quiet whenever the block waits for input
  `BWO_ASSERT(a_div_idle, s_axis_tready_o |-> !stat.div_busy, "divider busy while idle")
  // Reset leaves no result pending
  `BWO_ASSERT_ALWAYS(a_reset_clear, !rst_ni |=> !m_axis_tvalid_o, "output valid during reset")
endmodule
